/* rtl/core/smx_pkg.sv */
// Shared types and constants for the stack machine execute unit.
// Used by smx_stack, smx_decode and the top level; depends on nothing.
package smx_pkg;

   localparam logic [7:0] OP_END   = 8'h00;
   localparam logic [7:0] OP_STORE = 8'h01;
   localparam logic [7:0] OP_ADD   = 8'h02;
   localparam logic [7:0] OP_PUSH  = 8'h03;
   localparam logic [7:0] OP_LOAD  = 8'h05;
   localparam logic [7:0] OP_JLT   = 8'h06;
   localparam logic [7:0] OP_PRINT = 8'h07;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_OVER    = 3'd1;
   localparam logic [2:0] ERR_UNDER   = 3'd2;
   localparam logic [2:0] ERR_ADDR    = 3'd3;
   localparam logic [2:0] ERR_ILLEGAL = 3'd4;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] operand;
   } req_type;

   typedef struct packed {
      logic [7:0]        next_pc;
      logic              print_valid;
      logic signed [7:0] print_value;
      logic              halted;
      logic [2:0]        error_code;
   } rsp_type;

   typedef enum logic [2:0] {
      STK_HOLD,
      STK_PUSH,
      STK_POP,
      STK_POP2,
      STK_ADD
   } stk_op_type;

   typedef struct packed {
      stk_op_type stk_op;
      logic [7:0] stk_value;
      logic       mem_we;
      logic       halt_set;
   } ctl_type;

endpackage

/* rtl/core/smx_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module smx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                   wdata,
   input  logic                               re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                   rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/smx_stack.sv */
// Operand stack kept as a shift register with the top entry at index 0.
// Depends on smx_pkg for the stack operation codes.
module smx_stack #(
   parameter int STACK_DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  smx_pkg::stk_op_type                  op,
   input  logic [7:0]                           value,
   output logic [7:0]                           top,
   output logic [7:0]                           below,
   output logic [$clog2(STACK_DEPTH+1)-1:0]     count
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [7:0]    entries_ff [STACK_DEPTH];
   logic [7:0]    entries_in [STACK_DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      case (op)
         smx_pkg::STK_PUSH: begin
            entries_in[0] = value;
            for (int i = 1; i < STACK_DEPTH; i++) begin
               entries_in[i] = entries_ff[i-1];
            end
            count_in = count_ff + CW'(1);
         end
         smx_pkg::STK_POP: begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
               entries_in[i] = entries_ff[i+1];
            end
            entries_in[STACK_DEPTH-1] = 8'd0;
            count_in = count_ff - CW'(1);
         end
         smx_pkg::STK_POP2: begin
            for (int i = 0; i < STACK_DEPTH - 2; i++) begin
               entries_in[i] = entries_ff[i+2];
            end
            entries_in[STACK_DEPTH-2] = 8'd0;
            entries_in[STACK_DEPTH-1] = 8'd0;
            count_in = count_ff - CW'(2);
         end
         smx_pkg::STK_ADD: begin
            // Two entries leave and their sum takes the top.
            entries_in[0] = value;
            for (int i = 1; i < STACK_DEPTH - 1; i++) begin
               entries_in[i] = entries_ff[i+1];
            end
            entries_in[STACK_DEPTH-1] = 8'd0;
            count_in = count_ff - CW'(1);
         end
         default: begin
            entries_in = entries_ff;
            count_in   = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top   = entries_ff[0];
   assign below = entries_ff[1];
   assign count = count_ff;

endmodule

/* rtl/core/smx_decode.sv */
// Combinational execute logic: decodes one instruction against the current
// machine state. Depends on smx_pkg for opcodes, error codes and types.
module smx_decode #(
   parameter int STACK_DEPTH = 8,
   parameter int MEM_WORDS   = 4
) (
   input  smx_pkg::req_type                     item,
   input  logic [$clog2(STACK_DEPTH+1)-1:0]     count,
   input  logic [7:0]                           top,
   input  logic [7:0]                           below,
   input  logic [7:0]                           mem_word,
   input  logic [7:0]                           pc,
   input  logic                                 halt,
   output smx_pkg::ctl_type                     ctl,
   output smx_pkg::rsp_type                     rsp
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic          addr_bad;
   logic          full;
   logic          lt_two;
   logic          empty;
   logic [7:0]    pc_plus1;
   logic [7:0]    pc_plus2;
   logic [2:0]    err;
   logic [7:0]    pc_new;

   assign addr_bad = {1'b0, item.operand} >= 9'(MEM_WORDS);
   assign full     = count >= CW'(STACK_DEPTH);
   assign lt_two   = count < CW'(2);
   assign empty    = count == '0;
   assign pc_plus1 = pc + 8'd1;
   assign pc_plus2 = pc + 8'd2;

   always_comb begin
      ctl.stk_op    = smx_pkg::STK_HOLD;
      ctl.stk_value = item.operand;
      ctl.mem_we    = 1'b0;
      ctl.halt_set  = 1'b0;
      err           = smx_pkg::ERR_NONE;
      pc_new        = pc;
      rsp.print_valid = 1'b0;
      rsp.print_value = 8'sd0;
      if (!halt) begin
         unique case (item.opcode)
            smx_pkg::OP_END: begin
               ctl.halt_set = 1'b1;
            end
            smx_pkg::OP_STORE: begin
               if (addr_bad) begin
                  err = smx_pkg::ERR_ADDR;
               end else if (empty) begin
                  err = smx_pkg::ERR_UNDER;
               end else begin
                  ctl.mem_we = 1'b1;
                  ctl.stk_op = smx_pkg::STK_POP;
                  pc_new     = pc_plus2;
               end
            end
            smx_pkg::OP_LOAD: begin
               if (addr_bad) begin
                  err = smx_pkg::ERR_ADDR;
               end else if (full) begin
                  err = smx_pkg::ERR_OVER;
               end else begin
                  ctl.stk_op    = smx_pkg::STK_PUSH;
                  ctl.stk_value = mem_word;
                  pc_new        = pc_plus2;
               end
            end
            smx_pkg::OP_PUSH: begin
               if (full) begin
                  err = smx_pkg::ERR_OVER;
               end else begin
                  ctl.stk_op = smx_pkg::STK_PUSH;
                  pc_new     = pc_plus2;
               end
            end
            smx_pkg::OP_ADD: begin
               if (lt_two) begin
                  err = smx_pkg::ERR_UNDER;
               end else begin
                  ctl.stk_op    = smx_pkg::STK_ADD;
                  ctl.stk_value = top + below;
                  pc_new        = pc_plus1;
               end
            end
            smx_pkg::OP_JLT: begin
               if (lt_two) begin
                  err = smx_pkg::ERR_UNDER;
               end else begin
                  ctl.stk_op = smx_pkg::STK_POP2;
                  pc_new = ($signed(below) < $signed(top)) ? item.operand : pc_plus2;
               end
            end
            smx_pkg::OP_PRINT: begin
               if (addr_bad) begin
                  err = smx_pkg::ERR_ADDR;
               end else begin
                  rsp.print_valid = 1'b1;
                  rsp.print_value = $signed(mem_word);
                  pc_new          = pc_plus2;
               end
            end
            default: begin
               err = smx_pkg::ERR_ILLEGAL;
            end
         endcase
         if (err != smx_pkg::ERR_NONE) begin
            ctl.halt_set = 1'b1;
         end
      end
      rsp.next_pc    = pc_new;
      rsp.halted     = halt | ctl.halt_set;
      rsp.error_code = err;
   end

endmodule

/* rtl/core/stack_machine_execute_unit.sv */
// Top level of the stack machine execute unit.
// Depends on smx_pkg, smx_ram, smx_stack and smx_decode.

// The unit executes one fetched instruction (opcode and operand byte) per
// item and returns one result item for each: the next program counter, a
// printed data word if any, the halt flag and an error code. It sustains one
// instruction per clock cycle unless rsp_stall holds a full result register.
// The data memory word at the operand address is read into a register as
// the item is taken into the input register, and the execute step then
// writes the result register once that register is free or being emptied.
// Back-to-back instructions see each other's effects: a store followed at
// once by a load or print of the same address has its data forwarded around
// the memory. The data memory comes out of reset reading all zero through a
// per-word valid bit, so there is no clearing pass and the unit takes items
// from the first cycle after reset. Once an end instruction or a faulting
// instruction has set the halt flag, every later item is answered with the
// held program counter, halted set and no error, and only reset restarts
// the machine.
module stack_machine_execute_unit #(
   parameter int STACK_DEPTH = 8,
   parameter int MEM_WORDS   = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  smx_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output smx_pkg::rsp_type rsp_item
);

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   // Input register: holds the instruction while its memory word is read.
   smx_pkg::req_type req_ff;
   logic             req_valid_ff;
   logic             req_valid_in;

   // Result register.
   smx_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   // Machine state kept here; the stack lives in smx_stack.
   logic [7:0]           pc_ff;
   logic [7:0]           pc_in;
   logic                 halt_ff;
   logic                 halt_in;
   logic [MEM_WORDS-1:0] mem_valid_ff;
   logic [MEM_WORDS-1:0] mem_valid_in;

   // Forwarding of a store that retires in the same cycle the read is issued.
   logic       fwd_ff;
   logic       fwd_in;
   logic [7:0] fwd_data_ff;
   logic       word_valid_ff;
   logic       word_valid_in;

   logic                 accept_in;
   logic                 exec;
   logic [AW-1:0]        raddr;
   logic [AW-1:0]        waddr;
   logic                 mem_we;
   logic [7:0]           ram_rdata;
   logic [7:0]           mem_word;
   logic [7:0]           stk_top;
   logic [7:0]           stk_below;
   logic [CW-1:0]        stk_count;
   smx_pkg::stk_op_type  stk_op;
   smx_pkg::ctl_type     ctl;
   smx_pkg::rsp_type     rsp_next;

   // The instruction in the input register executes whenever the result
   // register is free or is being emptied in this cycle.
   assign exec      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !exec;
   assign accept_in = req_valid && !req_stall;

   assign raddr  = req_item.operand[AW-1:0];
   assign waddr  = req_ff.operand[AW-1:0];
   assign mem_we = exec && ctl.mem_we;
   assign stk_op = exec ? ctl.stk_op : smx_pkg::STK_HOLD;

   smx_ram #(
      .WIDTH (8),
      .DEPTH (MEM_WORDS)
   ) u_data_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (waddr),
      .wdata (stk_top),
      .re    (accept_in),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   smx_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .op    (stk_op),
      .value (ctl.stk_value),
      .top   (stk_top),
      .below (stk_below),
      .count (stk_count)
   );

   // A word that was never written reads as zero.
   assign mem_word = fwd_ff ? fwd_data_ff : (word_valid_ff ? ram_rdata : 8'd0);

   smx_decode #(
      .STACK_DEPTH (STACK_DEPTH),
      .MEM_WORDS   (MEM_WORDS)
   ) u_decode (
      .item     (req_ff),
      .count    (stk_count),
      .top      (stk_top),
      .below    (stk_below),
      .mem_word (mem_word),
      .pc       (pc_ff),
      .halt     (halt_ff),
      .ctl      (ctl),
      .rsp      (rsp_next)
   );

   always_comb begin
      req_valid_in  = accept_in ? 1'b1 : (req_valid_ff && !exec);
      rsp_valid_in  = exec ? 1'b1 : (rsp_valid_ff && rsp_stall);
      pc_in         = exec ? rsp_next.next_pc : pc_ff;
      halt_in       = exec ? (halt_ff | ctl.halt_set) : halt_ff;
      mem_valid_in  = mem_valid_ff;
      if (mem_we) begin
         mem_valid_in[waddr] = 1'b1;
      end
      // The full operand is compared so an out-of-range read never matches.
      fwd_in        = mem_we && (req_ff.operand == req_item.operand);
      word_valid_in = mem_valid_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= 8'd0;
         halt_ff      <= 1'b0;
         mem_valid_ff <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         mem_valid_ff <= mem_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         req_ff        <= req_item;
         fwd_ff        <= fwd_in;
         fwd_data_ff   <= stk_top;
         word_valid_ff <= word_valid_in;
      end
      if (exec) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
